/* sv/mex_pkg.sv */
// shared types and codes for the mips execute stage with forwarding
// depends on nothing; used by the interfaces and every module of the block
package mex_pkg;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL  = 6'h00;
  localparam logic [5:0] OP_ADDI     = 6'h08;
  localparam logic [5:0] OP_ADDIU    = 6'h09;
  localparam logic [5:0] OP_SLTI     = 6'h0A;
  localparam logic [5:0] OP_SLTIU    = 6'h0B;
  localparam logic [5:0] OP_ANDI     = 6'h0C;
  localparam logic [5:0] OP_ORI      = 6'h0D;
  localparam logic [5:0] OP_XORI     = 6'h0E;
  localparam logic [5:0] OP_LUI      = 6'h0F;
  localparam logic [5:0] OP_SPECIAL3 = 6'h1F;
  localparam logic [5:0] OP_LB       = 6'h20;
  localparam logic [5:0] OP_LW       = 6'h23;
  localparam logic [5:0] OP_LBU      = 6'h24;
  localparam logic [5:0] OP_LHU      = 6'h25;
  localparam logic [5:0] OP_SB       = 6'h28;
  localparam logic [5:0] OP_SH       = 6'h29;
  localparam logic [5:0] OP_SW       = 6'h2B;

  // function codes under OP_SPECIAL
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_MOVZ = 6'h0A;
  localparam logic [5:0] FN_MOVN = 6'h0B;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  localparam logic [4:0]  REG_ZERO  = 5'd0;
  localparam logic [31:0] MASK_BYTE = 32'h0000_00FF;
  localparam logic [1:0]  BYTE_LAST = 2'd3;

  typedef struct packed {
    logic               bubble_in;
    logic [5:0]         opcode;
    logic [5:0]         funct;
    logic [4:0]         shamt;
    logic [4:0]         rs_index;
    logic [4:0]         rt_index;
    logic [4:0]         rd_index;
    logic signed [31:0] rs_value;
    logic signed [31:0] rt_value;
    logic signed [15:0] immediate;
    logic [4:0]         memwb_dest;
    logic signed [31:0] memwb_value;
  } issue_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [4:0]         dest_reg;
    logic               reg_write;
    logic               mem_read;
    logic               mem_write;
    logic [29:0]        word_address;
    logic [1:0]         byte_index;
    logic signed [31:0] store_data;
    logic [5:0]         opcode_out;
    logic               bubble_out;
    logic               misaligned;
    logic               invalid_op;
  } result_t;

  // what the stage remembers of its previous item for forwarding
  typedef struct packed {
    logic [31:0] last_result;
    logic [4:0]  last_dest;
  } fwd_state_t;

endpackage

/* sv/mex_issue_if.sv */
// issue channel of the execute stage: one decoded instruction per item
// depends on mex_pkg
interface mex_issue_if;
  logic            valid;
  logic            ready;
  mex_pkg::issue_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/mex_result_if.sv */
// result channel of the execute stage: one result item per instruction
// depends on mex_pkg
interface mex_result_if;
  logic             valid;
  logic             ready;
  mex_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/mex_fwd.sv */
// operand forwarding: own last result first, then write-back bus, then register file
// depends on mex_pkg
module mex_fwd (
  input  mex_pkg::issue_t     item,
  input  mex_pkg::fwd_state_t state,
  output logic [31:0]         op_a,
  output logic [31:0]         op_b
);

  always_comb begin
    if (state.last_dest != mex_pkg::REG_ZERO && state.last_dest == item.rs_index) begin
      op_a = state.last_result;
    end else if (item.memwb_dest != mex_pkg::REG_ZERO && item.memwb_dest == item.rs_index) begin
      op_a = item.memwb_value;
    end else begin
      op_a = item.rs_value;
    end
  end

  always_comb begin
    if (state.last_dest != mex_pkg::REG_ZERO && state.last_dest == item.rt_index) begin
      op_b = state.last_result;
    end else if (item.memwb_dest != mex_pkg::REG_ZERO && item.memwb_dest == item.rt_index) begin
      op_b = item.memwb_value;
    end else begin
      op_b = item.rt_value;
    end
  end

endmodule

/* sv/mex_alu.sv */
// decode, alu, address generation and bubble/error handling for one item
// depends on mex_pkg
module mex_alu (
  input  mex_pkg::issue_t  item,
  input  logic [31:0]      op_a,
  input  logic [31:0]      op_b,
  output mex_pkg::result_t res
);

  logic [31:0] imm_se;
  logic [31:0] imm_ze;
  logic [31:0] eff_addr;
  logic        valid_op;
  logic        fail_move;
  logic        mis;

  assign imm_se   = {{16{item.immediate[15]}}, item.immediate};
  assign imm_ze   = {16'h0000, item.immediate};
  assign eff_addr = op_a + imm_se;

  always_comb begin
    res       = '0;
    valid_op  = 1'b1;
    fail_move = 1'b0;
    mis       = 1'b0;
    res.opcode_out = item.opcode;
    if (item.bubble_in) begin
      res.opcode_out = '0;
      res.bubble_out = 1'b1;
    end else begin
      case (item.opcode)
        mex_pkg::OP_SPECIAL3: begin
          // seb
          res.result_value = {{24{op_b[7]}}, op_b[7:0]};
          res.dest_reg     = item.rd_index;
          res.reg_write    = 1'b1;
        end
        mex_pkg::OP_SPECIAL: begin
          res.dest_reg  = item.rd_index;
          res.reg_write = 1'b1;
          case (item.funct)
            mex_pkg::FN_SLL:  res.result_value = op_b << item.shamt;
            mex_pkg::FN_SRL:  res.result_value = op_b >> item.shamt;
            mex_pkg::FN_MOVZ: begin
              if (op_b == 32'd0) res.result_value = op_a;
              else fail_move = 1'b1;
            end
            mex_pkg::FN_MOVN: begin
              if (op_b != 32'd0) res.result_value = op_a;
              else fail_move = 1'b1;
            end
            mex_pkg::FN_ADD, mex_pkg::FN_ADDU: res.result_value = op_a + op_b;
            mex_pkg::FN_SUB, mex_pkg::FN_SUBU: res.result_value = op_a - op_b;
            mex_pkg::FN_AND:  res.result_value = op_a & op_b;
            mex_pkg::FN_OR:   res.result_value = op_a | op_b;
            mex_pkg::FN_XOR:  res.result_value = op_a ^ op_b;
            mex_pkg::FN_NOR:  res.result_value = ~(op_a | op_b);
            mex_pkg::FN_SLT:  res.result_value = {31'd0, $signed(op_a) < $signed(op_b)};
            mex_pkg::FN_SLTU: res.result_value = {31'd0, op_a < op_b};
            default:          valid_op = 1'b0;
          endcase
        end
        mex_pkg::OP_ADDI, mex_pkg::OP_ADDIU: begin
          res.result_value = op_a + imm_se;
          res.dest_reg     = item.rt_index;
          res.reg_write    = 1'b1;
        end
        mex_pkg::OP_SLTI: begin
          res.result_value = {31'd0, $signed(op_a) < $signed(imm_se)};
          res.dest_reg     = item.rt_index;
          res.reg_write    = 1'b1;
        end
        mex_pkg::OP_SLTIU: begin
          res.result_value = {31'd0, op_a < imm_se};
          res.dest_reg     = item.rt_index;
          res.reg_write    = 1'b1;
        end
        mex_pkg::OP_ANDI: begin
          res.result_value = op_a & imm_ze;
          res.dest_reg     = item.rt_index;
          res.reg_write    = 1'b1;
        end
        mex_pkg::OP_ORI: begin
          res.result_value = op_a | imm_ze;
          res.dest_reg     = item.rt_index;
          res.reg_write    = 1'b1;
        end
        mex_pkg::OP_XORI: begin
          res.result_value = op_a ^ imm_ze;
          res.dest_reg     = item.rt_index;
          res.reg_write    = 1'b1;
        end
        mex_pkg::OP_LUI: begin
          res.result_value = {item.immediate, 16'h0000};
          res.dest_reg     = item.rt_index;
          res.reg_write    = 1'b1;
        end
        mex_pkg::OP_LB, mex_pkg::OP_LW, mex_pkg::OP_LBU, mex_pkg::OP_LHU: begin
          res.word_address = eff_addr[31:2];
          res.byte_index   = eff_addr[1:0];
          if ((item.opcode == mex_pkg::OP_LW && eff_addr[1:0] != 2'd0) ||
              (item.opcode == mex_pkg::OP_LHU && eff_addr[1:0] == mex_pkg::BYTE_LAST)) begin
            mis = 1'b1;
          end else begin
            res.dest_reg  = item.rt_index;
            res.reg_write = 1'b1;
            res.mem_read  = 1'b1;
          end
        end
        mex_pkg::OP_SB, mex_pkg::OP_SH, mex_pkg::OP_SW: begin
          res.word_address = eff_addr[31:2];
          res.byte_index   = eff_addr[1:0];
          if ((item.opcode == mex_pkg::OP_SW && eff_addr[1:0] != 2'd0) ||
              (item.opcode == mex_pkg::OP_SH && eff_addr[1:0] == mex_pkg::BYTE_LAST)) begin
            mis = 1'b1;
          end else begin
            res.mem_write  = 1'b1;
            res.store_data = (item.opcode == mex_pkg::OP_SB) ? (op_b & mex_pkg::MASK_BYTE)
                                                             : op_b;
          end
        end
        default: valid_op = 1'b0;
      endcase

      if (!valid_op) begin
        res.invalid_op   = 1'b1;
        res.bubble_out   = 1'b1;
        res.result_value = '0;
        res.dest_reg     = '0;
        res.reg_write    = 1'b0;
      end
      if (mis) begin
        res.misaligned = 1'b1;
        res.bubble_out = 1'b1;
      end
      if (fail_move) begin
        res.bubble_out   = 1'b1;
        res.result_value = '0;
        res.dest_reg     = '0;
        res.reg_write    = 1'b0;
      end
    end
  end

endmodule

/* sv/mips_execute_stage_with_forwarding.sv */
// top level of the mips32 execute stage with operand forwarding
// depends on mex_pkg, mex_issue_if, mex_result_if, mex_fwd and mex_alu
//
//   channel  | dir | payload            | handshake
//   ---------+-----+--------------------+-------------------------------
//   issue    | in  | mex_pkg::issue_t   | valid/ready, taken when both high
//   result   | out | mex_pkg::result_t  | valid/ready, taken when both high
//
// one item per clock sustained while the result side is ready; from issue to result an item passes
// through the issue register, then the forwarding muxes and alu into the result register
// the forwarding state (last result and its destination) updates as an item moves
// from the issue register into the result register, so the next item sees it
// synchronous active-high rst empties both registers and clears the forwarding state
// a stalled result holds; the issue register keeps filling until both slots are full
module mips_execute_stage_with_forwarding (
  input logic          clk,
  input logic          rst,
  mex_issue_if.sink    issue,
  mex_result_if.source result
);

  // issue register
  logic                s1_valid;
  mex_pkg::issue_t     s1_item;

  // result register
  logic                out_valid;
  mex_pkg::result_t    out_item;

  // forwarding state
  logic [31:0]         last_result;
  logic [4:0]          last_dest;
  mex_pkg::fwd_state_t fwd_state;

  logic [31:0]         op_a;
  logic [31:0]         op_b;
  mex_pkg::result_t    alu_res;
  logic [4:0]          last_dest_next;
  logic                adv;
  logic                load;

  assign fwd_state.last_result = last_result;
  assign fwd_state.last_dest   = last_dest;

  // item moves to the result register when that slot is free or being drained
  assign adv          = s1_valid && (!out_valid || result.ready);
  assign issue.ready  = !s1_valid || adv;
  assign load         = issue.valid && issue.ready;

  assign result.valid = out_valid;
  assign result.data  = out_item;

  mex_fwd u_fwd (
    .item  (s1_item),
    .state (fwd_state),
    .op_a  (op_a),
    .op_b  (op_b)
  );

  mex_alu u_alu (
    .item  (s1_item),
    .op_a  (op_a),
    .op_b  (op_b),
    .res   (alu_res)
  );

  // loads leave nothing to forward here; their value comes back on the write-back bus
  assign last_dest_next = (alu_res.reg_write && !alu_res.mem_read) ? alu_res.dest_reg
                                                                   : mex_pkg::REG_ZERO;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      last_result <= '0;
      last_dest   <= '0;
    end else begin
      if (issue.ready) s1_valid <= issue.valid;
      if (adv) begin
        out_valid   <= 1'b1;
        last_result <= alu_res.result_value;
        last_dest   <= last_dest_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) s1_item <= issue.data;
    if (adv) out_item <= alu_res;
  end

  // checks

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!s1_valid && !out_valid && last_dest == mex_pkg::REG_ZERO))
    else $error("reset left the stage or forwarding state non-empty");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(last_dest) && $stable(last_result)))
    else $error("forwarding state changed without an item moving");

  a_fwd_matches_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> (last_dest == mex_pkg::REG_ZERO ||
             (out_item.reg_write && !out_item.mem_read && out_item.dest_reg == last_dest &&
              out_item.result_value == last_result)))
    else $error("forwarding state disagrees with the result it came from");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |=> out_valid)
    else $error("stalled result lost");

  a_bubble_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_item.misaligned || out_item.invalid_op)) |->
      (out_item.bubble_out && !out_item.reg_write && !out_item.mem_read &&
       !out_item.mem_write))
    else $error("faulted item still does work downstream");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// self-checking bench for the mips32 execute stage with forwarding
// depends on mex_pkg, mex_issue_if, mex_result_if and the stage top level
module tb;
  import mex_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int LIMIT_CYCLES = 300000;
  localparam int N_RANDOM     = 1030;
  localparam int HOLD_CYCLES  = 160;

  // codes the stage does not support
  localparam logic [5:0] OP_UNUSED = 6'h3F;
  localparam logic [5:0] FN_UNUSED = 6'h01;

  // one instruction waiting to be issued, with its lead-in gap
  typedef struct packed {
    issue_t     ins;
    logic [3:0] gap;
    logic       drain;
  } pending_t;

  logic clk = 1'b0;
  logic rst;

  mex_issue_if  issue_ch ();
  mex_result_if result_ch ();

  mips_execute_stage_with_forwarding dut (
    .clk    (clk),
    .rst    (rst),
    .issue  (issue_ch),
    .result (result_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  pending_t instr_q[$];
  result_t  expected_q[$];

  // forwarding state of the predicted stage
  logic [31:0] fwd_value = '0;
  logic [4:0]  fwd_reg   = REG_ZERO;

  int pending_cnt  = 0;
  int n_results    = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  int next_hold_at = 300;
  int gap_count    = 0;
  int n_fail       = 0;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // newest source wins: own last result, then the write-back bus, then the regfile
  function automatic logic [31:0] forward_operand(logic [4:0] idx, logic [31:0] rf_value,
                                                  issue_t ins);
    if (fwd_reg != REG_ZERO && fwd_reg == idx) return fwd_value;
    if (ins.memwb_dest != REG_ZERO && ins.memwb_dest == idx) return ins.memwb_value;
    return rf_value;
  endfunction

  // what the stage must produce for one instruction; advances the forwarding state
  function automatic result_t execute_predict(issue_t ins);
    result_t     r;
    logic [31:0] a, b, sx, zx, ea, res;
    logic        supported, move_failed;
    r           = '0;
    res         = '0;
    supported   = 1'b1;
    move_failed = 1'b0;
    r.opcode_out = ins.opcode;
    if (ins.bubble_in) begin
      r.opcode_out = '0;
      r.bubble_out = 1'b1;
    end else begin
      a  = forward_operand(ins.rs_index, ins.rs_value, ins);
      b  = forward_operand(ins.rt_index, ins.rt_value, ins);
      sx = {{16{ins.immediate[15]}}, ins.immediate};
      zx = {16'h0000, ins.immediate};
      ea = a + sx;
      if (ins.opcode == OP_SPECIAL3) begin
        // seb: sign-extend the low byte of rt
        res         = {{24{b[7]}}, b[7:0]};
        r.dest_reg  = ins.rd_index;
        r.reg_write = 1'b1;
      end else if (ins.opcode == OP_SPECIAL) begin
        r.dest_reg  = ins.rd_index;
        r.reg_write = 1'b1;
        case (ins.funct)
          FN_SLL:          res = b << ins.shamt;
          FN_SRL:          res = b >> ins.shamt;
          FN_MOVZ:         if (b == '0) res = a; else move_failed = 1'b1;
          FN_MOVN:         if (b != '0) res = a; else move_failed = 1'b1;
          FN_ADD, FN_ADDU: res = a + b;
          FN_SUB, FN_SUBU: res = a - b;
          FN_AND:          res = a & b;
          FN_OR:           res = a | b;
          FN_XOR:          res = a ^ b;
          FN_NOR:          res = ~(a | b);
          FN_SLT:          res = {31'b0, $signed(a) < $signed(b)};
          FN_SLTU:         res = {31'b0, a < b};
          default:         supported = 1'b0;
        endcase
      end else begin
        case (ins.opcode)
          OP_ADDI, OP_ADDIU: res = a + sx;
          OP_SLTI:           res = {31'b0, $signed(a) < $signed(sx)};
          OP_SLTIU:          res = {31'b0, a < sx};
          OP_ANDI:           res = a & zx;
          OP_ORI:            res = a | zx;
          OP_XORI:           res = a ^ zx;
          OP_LUI:            res = {ins.immediate, 16'h0000};
          OP_LB, OP_LW, OP_LBU, OP_LHU: begin
            r.word_address = ea[31:2];
            r.byte_index   = ea[1:0];
            if ((ins.opcode == OP_LW && ea[1:0] != 2'd0) ||
                (ins.opcode == OP_LHU && ea[1:0] == BYTE_LAST))
              r.misaligned = 1'b1;
            else
              r.mem_read = 1'b1;
          end
          OP_SB, OP_SH, OP_SW: begin
            r.word_address = ea[31:2];
            r.byte_index   = ea[1:0];
            if ((ins.opcode == OP_SW && ea[1:0] != 2'd0) ||
                (ins.opcode == OP_SH && ea[1:0] == BYTE_LAST))
              r.misaligned = 1'b1;
            else begin
              r.mem_write  = 1'b1;
              r.store_data = (ins.opcode == OP_SB) ? (b & MASK_BYTE) : b;
            end
          end
          default: supported = 1'b0;
        endcase
        // immediates and loads write rt; stores and misaligned loads write nothing
        if (supported && !r.misaligned && !(ins.opcode inside {OP_SB, OP_SH, OP_SW})) begin
          r.dest_reg  = ins.rt_index;
          r.reg_write = 1'b1;
        end
      end
      if (move_failed) begin
        r.dest_reg   = REG_ZERO;
        r.reg_write  = 1'b0;
        r.bubble_out = 1'b1;
      end
      if (!supported) begin
        r.invalid_op = 1'b1;
        r.bubble_out = 1'b1;
        r.dest_reg   = REG_ZERO;
        r.reg_write  = 1'b0;
        res          = '0;
      end
      if (r.misaligned) r.bubble_out = 1'b1;
    end
    r.result_value = res;
    // a load's value is unknown here, so it is never forwarded from this stage
    fwd_value = res;
    fwd_reg   = (r.reg_write && !r.mem_read) ? r.dest_reg : REG_ZERO;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      n_fail++;
    end
  endtask

  task automatic check_result(result_t want, result_t got);
    check_field("result_value", want.result_value, got.result_value);
    check_field("dest_reg",     32'(want.dest_reg),     32'(got.dest_reg));
    check_field("reg_write",    32'(want.reg_write),    32'(got.reg_write));
    check_field("mem_read",     32'(want.mem_read),     32'(got.mem_read));
    check_field("mem_write",    32'(want.mem_write),    32'(got.mem_write));
    check_field("word_address", 32'(want.word_address), 32'(got.word_address));
    check_field("byte_index",   32'(want.byte_index),   32'(got.byte_index));
    check_field("store_data",   want.store_data,        got.store_data);
    check_field("opcode_out",   32'(want.opcode_out),   32'(got.opcode_out));
    check_field("bubble_out",   32'(want.bubble_out),   32'(got.bubble_out));
    check_field("misaligned",   32'(want.misaligned),   32'(got.misaligned));
    check_field("invalid_op",   32'(want.invalid_op),   32'(got.invalid_op));
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic issue_t instr(logic [5:0] op, logic [5:0] fn, logic [4:0] sh,
                                   logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                   logic [31:0] rsv, logic [31:0] rtv, logic [15:0] imm,
                                   logic [4:0] wbd, logic [31:0] wbv);
    issue_t t;
    t.bubble_in   = 1'b0;
    t.opcode      = op;
    t.funct       = fn;
    t.shamt       = sh;
    t.rs_index    = rs;
    t.rt_index    = rt;
    t.rd_index    = rd;
    t.rs_value    = rsv;
    t.rt_value    = rtv;
    t.immediate   = imm;
    t.memwb_dest  = wbd;
    t.memwb_value = wbv;
    return t;
  endfunction

  task automatic queue_instr(issue_t ins, int gap, bit drain);
    pending_t p;
    p.ins   = ins;
    p.gap   = 4'(gap);
    p.drain = drain;
    instr_q.push_back(p);
  endtask

  // small register set most of the time so forwarding paths hit often
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 1) == 0) return 5'($urandom_range(0, 3));
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'hFFFF_FFFF;
      5:       return 32'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_half();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      3:       return 16'hFFFF;
      4:       return 16'($urandom_range(0, 15));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic issue_t random_instr();
    issue_t t;
    int     k;
    t = instr(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
              5'($urandom_range(0, 31)), pick_reg(), pick_reg(), pick_reg(),
              pick_word(), pick_word(), pick_half(), pick_reg(), pick_word());
    k = $urandom_range(0, 99);
    // 4..8 keep the raw opcode and funct, mostly unsupported codes
    if (k < 4) begin
      t.bubble_in = 1'b1;
    end else if (k >= 9) begin
      if (k < 45) begin
        t.opcode = OP_SPECIAL;
        case ($urandom_range(0, 14))
          0:  t.funct = FN_SLL;
          1:  t.funct = FN_SRL;
          2:  t.funct = FN_MOVZ;
          3:  t.funct = FN_MOVN;
          4:  t.funct = FN_ADD;
          5:  t.funct = FN_ADDU;
          6:  t.funct = FN_SUB;
          7:  t.funct = FN_SUBU;
          8:  t.funct = FN_AND;
          9:  t.funct = FN_OR;
          10: t.funct = FN_XOR;
          11: t.funct = FN_NOR;
          12: t.funct = FN_SLT;
          13: t.funct = FN_SLTU;
          default: t.funct = t.funct;
        endcase
      end else if (k < 50) begin
        t.opcode = OP_SPECIAL3;
      end else if (k < 72) begin
        case ($urandom_range(0, 8))
          0: t.opcode = OP_ADDI;
          1: t.opcode = OP_ADDIU;
          2: t.opcode = OP_SLTI;
          3: t.opcode = OP_SLTIU;
          4: t.opcode = OP_ANDI;
          5: t.opcode = OP_ORI;
          6: t.opcode = OP_XORI;
          default: t.opcode = OP_LUI;
        endcase
      end else begin
        case ($urandom_range(0, 6))
          0: t.opcode = OP_LB;
          1: t.opcode = OP_LW;
          2: t.opcode = OP_LBU;
          3: t.opcode = OP_LHU;
          4: t.opcode = OP_SB;
          5: t.opcode = OP_SH;
          default: t.opcode = OP_SW;
        endcase
      end
    end
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // issue driver: offers the head of instr_q after its gap
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_issue
    logic offer;
    logic fresh;
    if (rst) begin
      issue_ch.valid <= 1'b0;
      issue_ch.data  <= '0;
      gap_count = 0;
    end else begin
      offer = issue_ch.valid;
      fresh = 1'b0;
      if (issue_ch.valid && issue_ch.ready) begin
        void'(instr_q.pop_front());
        offer     = 1'b0;
        fresh     = 1'b1;
        gap_count = 0;
      end
      if (!offer && instr_q.size() != 0) begin
        if (gap_count < int'(instr_q[0].gap)) begin
          gap_count++;
        // a drain item waits until every earlier result is back
        end else if (!instr_q[0].drain || (!fresh && pending_cnt == 0)) begin
          offer = 1'b1;
          issue_ch.data <= instr_q[0].ins;
        end
      end
      issue_ch.valid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: predicts on issue, checks on result, paces ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_result
    int s;
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left      <= 0;
    end else begin
      s = stall_left;
      // check first: a result this edge is always older than an issue this edge
      if (result_ch.valid && result_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected: %h", result_ch.data);
          n_fail++;
        end else begin
          check_result(expected_q.pop_front(), result_ch.data);
        end
        n_results <= n_results + 1;
        // every third stretch of 70 results runs without stalls
        s = ((n_results / 70) % 3 == 1) ? 0 : int'($urandom_range(0, 14));
      end else if (s > 0) begin
        s--;
      end
      if (issue_ch.valid && issue_ch.ready)
        expected_q.push_back(execute_predict(issue_ch.data));
      stall_left      <= s;
      result_ch.ready <= (s == 0) && (hold_left == 0);
      pending_cnt     <= expected_q.size();
    end
  end

  // long receiver hold-off so the stage fills and backs up its issue side
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (n_results >= next_hold_at) begin
      hold_left    <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + 450;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    issue_t t;
    int     i;
    rst <= 1'b1;

    // wraparound add, its result forwarded into a sub
    queue_instr(instr(OP_SPECIAL, FN_ADD, 5'd0, 5'd1, 5'd2, 5'd3, 32'h7FFF_FFFF,
                      32'h1, 16'h0, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    queue_instr(instr(OP_SPECIAL, FN_SUB, 5'd0, 5'd3, 5'd2, 5'd4, 32'h5555,
                      32'h1, 16'h0, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    // write-back bus feeds rs
    queue_instr(instr(OP_SPECIAL, FN_OR, 5'd0, 5'd5, 5'd4, 5'd6, 32'h0,
                      32'h0, 16'h0, 5'd5, 32'h0F0F_0000), $urandom_range(0, 14), 1'b0);
    // most negative immediate; own last result then beats the write-back bus
    queue_instr(instr(OP_ADDI, FN_SLL, 5'd0, 5'd0, 5'd7, 5'd0, 32'h1234_5678,
                      32'h0, 16'h8000, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    queue_instr(instr(OP_SPECIAL, FN_AND, 5'd0, 5'd7, 5'd7, 5'd8, 32'h1,
                      32'h2, 16'h0, 5'd7, 32'hDEAD_BEEF), $urandom_range(0, 14), 1'b0);
    // destination zero writes but register zero is never forwarded
    queue_instr(instr(OP_SPECIAL, FN_ADDU, 5'd0, 5'd1, 5'd2, 5'd0, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 16'h0, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    queue_instr(instr(OP_SPECIAL, FN_XOR, 5'd0, 5'd0, 5'd0, 5'd9, 32'h0000_FFFF,
                      32'hFFFF_0000, 16'h0, 5'd0, 32'h1), $urandom_range(0, 14), 1'b0);
    // full-distance shifts, srl must be logical
    queue_instr(instr(OP_SPECIAL, FN_SLL, 5'd31, 5'd0, 5'd10, 5'd11, 32'h0,
                      32'h1, 16'h0, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    queue_instr(instr(OP_SPECIAL, FN_SRL, 5'd31, 5'd0, 5'd11, 5'd12, 32'h0,
                      32'h0, 16'h0, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    // conditional moves, taken and failed
    queue_instr(instr(OP_SPECIAL, FN_MOVZ, 5'd0, 5'd1, 5'd13, 5'd14, 32'hA5A5_A5A5,
                      32'h0, 16'h0, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    queue_instr(instr(OP_SPECIAL, FN_MOVZ, 5'd0, 5'd1, 5'd13, 5'd14, 32'hA5A5_A5A5,
                      32'h5, 16'h0, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    queue_instr(instr(OP_SPECIAL, FN_MOVN, 5'd0, 5'd1, 5'd13, 5'd15, 32'h5A5A_5A5A,
                      32'h0, 16'h0, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    queue_instr(instr(OP_SPECIAL, FN_MOVN, 5'd0, 5'd1, 5'd13, 5'd15, 32'h5A5A_5A5A,
                      32'h8000_0000, 16'h0, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    // signed against unsigned compares
    queue_instr(instr(OP_SPECIAL, FN_SLT, 5'd0, 5'd20, 5'd21, 5'd22, 32'hFFFF_FFFF,
                      32'h1, 16'h0, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    queue_instr(instr(OP_SPECIAL, FN_SLTU, 5'd0, 5'd20, 5'd21, 5'd23, 32'hFFFF_FFFF,
                      32'h1, 16'h0, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    queue_instr(instr(OP_SLTIU, FN_SLL, 5'd0, 5'd24, 5'd25, 5'd0, 32'h1,
                      32'h0, 16'hFFFF, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    // zero-extended logic immediate, lui, seb
    queue_instr(instr(OP_ANDI, FN_SLL, 5'd0, 5'd24, 5'd25, 5'd0, 32'hFFFF_FFFF,
                      32'h0, 16'h8000, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    queue_instr(instr(OP_LUI, FN_SLL, 5'd0, 5'd24, 5'd25, 5'd0, 32'h0,
                      32'h0, 16'h8000, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    queue_instr(instr(OP_SPECIAL3, FN_SLL, 5'd0, 5'd0, 5'd26, 5'd27, 32'h0,
                      32'h0000_0080, 16'h0, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    // aligned load; its value must come from the write-back bus, not this stage
    queue_instr(instr(OP_LW, FN_SLL, 5'd0, 5'd27, 5'd28, 5'd0, 32'h1000,
                      32'h0, 16'hFFFC, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    queue_instr(instr(OP_SPECIAL, FN_ADD, 5'd0, 5'd28, 5'd0, 5'd29, 32'h0,
                      32'h0, 16'h0, 5'd28, 32'h77), $urandom_range(0, 14), 1'b0);
    // misaligned word and halfword accesses
    queue_instr(instr(OP_LW, FN_SLL, 5'd0, 5'd27, 5'd28, 5'd0, 32'h1001,
                      32'h0, 16'h0, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    queue_instr(instr(OP_LHU, FN_SLL, 5'd0, 5'd27, 5'd28, 5'd0, 32'h1003,
                      32'h0, 16'h0, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    queue_instr(instr(OP_SH, FN_SLL, 5'd0, 5'd27, 5'd30, 5'd0, 32'h2000,
                      32'h1234_5678, 16'h3, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    // byte store masks data; word store address wraps to zero
    queue_instr(instr(OP_SB, FN_SLL, 5'd0, 5'd27, 5'd30, 5'd0, 32'h2000,
                      32'h1234_5678, 16'h1, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    queue_instr(instr(OP_SW, FN_SLL, 5'd0, 5'd27, 5'd30, 5'd0, 32'hFFFF_FFF0,
                      32'hCAFE_F00D, 16'h0010, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    // unsupported opcode and funct, then an empty slot
    queue_instr(instr(OP_UNUSED, FN_SLL, 5'd0, 5'd1, 5'd2, 5'd3, 32'h1,
                      32'h1, 16'h1, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    queue_instr(instr(OP_SPECIAL, FN_UNUSED, 5'd0, 5'd1, 5'd2, 5'd3, 32'h1,
                      32'h1, 16'h1, 5'd0, 32'h0), $urandom_range(0, 14), 1'b0);
    t = instr(OP_ADDI, FN_SLL, 5'd0, 5'd1, 5'd2, 5'd3, 32'h1, 32'h1, 16'h1, 5'd0, 32'h0);
    t.bubble_in = 1'b1;
    queue_instr(t, $urandom_range(0, 14), 1'b0);

    // random part: every third stretch of 64 items has no gaps,
    // and now and then the sender drains the stage before going on
    for (i = 0; i < N_RANDOM; i++)
      queue_instr(random_instr(), ((i / 64) % 3 == 1) ? 0 : int'($urandom_range(0, 14)),
                  (i % 150) == 75);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (instr_q.size() != 0) @(posedge clk);
    @(posedge clk);
    for (i = 0; i < 5000 && pending_cnt != 0; i++) @(posedge clk);
    // wait on past the drain, to catch stray results
    repeat (8) @(posedge clk);

    if (pending_cnt != 0)
      $error("%0d expected results never arrived", pending_cnt);
    if (n_fail == 0 && pending_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* files.f */
sv/mex_pkg.sv
sv/mex_issue_if.sv
sv/mex_result_if.sv
sv/mex_fwd.sv
sv/mex_alu.sv
sv/mips_execute_stage_with_forwarding.sv
tb/tb.sv
